// ===== rtl/scbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants for the servo command byte parser.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int BufferBytes = 32;
  localparam int MaxLegs     = (BufferBytes - 1) / 3;
  localparam int LegAW       = (MaxLegs > 1) ? $clog2(MaxLegs) : 1;
  localparam int LegCW       = $clog2(MaxLegs + 1);
  localparam int LeftW       = $clog2(3 * MaxLegs + 1);
  localparam int RecvW       = $clog2(BufferBytes + 1);
  localparam int DataW       = 7;
  localparam int PosW        = 14;
  localparam int LegRamW     = 3 * DataW;
  localparam int MaxValidLeg = 5;
  localparam int OutDataW    = 32;
  localparam int CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CFG_MOVE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ECHO  = 2'd3;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ECHO  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_QUERY = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_ECHO  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_INTERRUPT = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_STRAY     = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_t;

  // follow-up action decided when a byte is applied
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_ERR1  = 3'd2,
    ACT_ERR2  = 3'd3,
    ACT_ERR3  = 3'd4,
    ACT_QUERY = 3'd5,
    ACT_ECHO  = 3'd6,
    ACT_LEGS  = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    SEL_ERR0 = 2'd0,
    SEL_ACT  = 2'd1,
    SEL_LEG  = 2'd2
  } sel_t;

  typedef struct packed {
    logic load_byte;
    logic apply;
    logic emit;
    sel_t emit_sel;
    logic last;
    logic leg_clear;
    logic leg_read;
    logic leg_next;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cmd;
    logic pending;
    logic act_next_none;
    act_t act;
    logic out_free;
    logic leg_last;
  } dp_status_t;

  typedef struct packed {
    kind_t            kind;
    logic [DataW-1:0] leg;
    logic             leg_invalid;
    logic [PosW-1:0]  position;
    logic [DataW-1:0] arg_byte;
    err_t             error_code;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/scbp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scbp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_datapath
// Code registers, parse state, leg store and output register of the parser.
// ----------------------------------------------------------------------------
module scbp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [scbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic [7:0]                    in_byte,
  input  wire scbp_pkg::dp_cmd_t             cmd,
  output scbp_pkg::dp_status_t               st,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output scbp_pkg::result_t                  out_res
);
  import scbp_pkg::*;

  logic [7:0] move_code, query_code, stop_code, echo_code;
  logic [7:0] byte_q;
  cmd_code_t  cur, cur_next;
  logic [LeftW-1:0] bytes_left, left_next;
  logic [RecvW-1:0] bytes_received, recv_next;
  logic [DataW-1:0] arg_q;
  act_t act, act_next;
  logic [1:0] phase;
  logic [DataW-1:0] hold_leg, hold_high;
  logic [LegAW-1:0] wr_leg, leg_idx;
  logic [LegRamW-1:0] ram_rdata;
  logic ram_we;
  logic [DataW-1:0] data7;
  logic [8:0] triple;
  logic is_cmd, pending, move_body;
  result_t res;

  assign data7     = byte_q[DataW-1:0];
  assign triple    = {2'b00, data7} + {1'b0, data7, 1'b0};
  assign is_cmd    = byte_q[7];
  assign pending   = (bytes_left != '0);
  assign move_body = !is_cmd && pending && (cur == CMD_MOVE) && (bytes_received != '0);
  assign ram_we    = cmd.apply && move_body && (phase == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      move_code  <= 8'd128;
      query_code <= 8'd129;
      stop_code  <= 8'd130;
      echo_code  <= 8'd131;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MOVE:  move_code  <= cfg_data;
        CFG_QUERY: query_code <= cfg_data;
        CFG_STOP:  stop_code  <= cfg_data;
        CFG_ECHO:  echo_code  <= cfg_data;
        default:   move_code  <= move_code;
      endcase
    end
  end

  always_comb begin
    act_next  = ACT_NONE;
    left_next = bytes_left;
    recv_next = bytes_received;
    cur_next  = cur;
    if (is_cmd) begin
      recv_next = '0;
      left_next = '0;
      if (byte_q == move_code) begin
        cur_next  = CMD_MOVE;
        left_next = LeftW'(1);
      end else if (byte_q == query_code) begin
        cur_next  = CMD_QUERY;
        left_next = LeftW'(1);
      end else if (byte_q == stop_code) begin
        cur_next = CMD_STOP;
        act_next = ACT_STOP;
      end else if (byte_q == echo_code) begin
        cur_next  = CMD_ECHO;
        left_next = LeftW'(1);
      end else begin
        cur_next = CMD_MOVE;
        act_next = ACT_ERR1;
      end
    end else if (pending) begin
      recv_next = bytes_received + RecvW'(1);
      if (cur == CMD_MOVE && bytes_received == '0) begin
        if (data7 > DataW'(MaxLegs)) begin
          left_next = '0;
          recv_next = '0;
          act_next  = ACT_ERR3;
        end else begin
          left_next = triple[LeftW-1:0];
        end
      end else begin
        left_next = bytes_left - LeftW'(1);
        if (bytes_left == LeftW'(1)) begin
          unique case (cur)
            CMD_MOVE:  act_next = ACT_LEGS;
            CMD_QUERY: act_next = ACT_QUERY;
            CMD_STOP:  act_next = ACT_STOP;
            CMD_ECHO:  act_next = ACT_ECHO;
            default:   act_next = ACT_NONE;
          endcase
        end
      end
    end else begin
      act_next = ACT_ERR2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur            <= CMD_MOVE;
      bytes_left     <= '0;
      bytes_received <= '0;
      act            <= ACT_NONE;
      phase          <= 2'd0;
      wr_leg         <= '0;
      leg_idx        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.apply) begin
        cur            <= cur_next;
        bytes_left     <= left_next;
        bytes_received <= recv_next;
        act            <= act_next;
        if (!is_cmd && pending && bytes_received == '0) begin
          phase  <= 2'd0;
          wr_leg <= '0;
        end else if (move_body) begin
          if (phase == 2'd2) begin
            phase  <= 2'd0;
            wr_leg <= wr_leg + LegAW'(1);
          end else begin
            phase <= phase + 2'd1;
          end
        end
      end
      if (cmd.leg_clear) begin
        leg_idx <= '0;
      end else if (cmd.leg_next) begin
        leg_idx <= leg_idx + LegAW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_q <= in_byte;
    end
    if (cmd.apply && !is_cmd && pending && bytes_received == '0) begin
      arg_q <= data7;
    end
    if (cmd.apply && move_body) begin
      if (phase == 2'd0) begin
        hold_leg <= data7;
      end
      if (phase == 2'd1) begin
        hold_high <= data7;
      end
    end
    if (cmd.emit) begin
      out_res <= res;
    end
  end

  scbp_ram #(
    .WIDTH(LegRamW),
    .DEPTH(MaxLegs)
  ) u_leg_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_leg),
    .wdata({hold_leg, hold_high, data7}),
    .re   (cmd.leg_read),
    .raddr(leg_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    res = '0;
    unique case (cmd.emit_sel)
      SEL_ERR0: begin
        res.kind       = KIND_ERROR;
        res.error_code = ERR_INTERRUPT;
      end
      SEL_ACT: begin
        case (act)
          ACT_STOP:  res.kind = KIND_STOP;
          ACT_ERR1: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_UNKNOWN;
          end
          ACT_ERR2: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_STRAY;
          end
          ACT_ERR3: begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_OVERFLOW;
          end
          ACT_QUERY: begin
            res.kind     = KIND_QUERY;
            res.arg_byte = arg_q;
          end
          ACT_ECHO: begin
            res.kind     = KIND_ECHO;
            res.arg_byte = arg_q;
          end
          default: res.kind = KIND_ERROR;
        endcase
      end
      SEL_LEG: begin
        res.kind        = KIND_MOVE;
        res.leg         = ram_rdata[LegRamW-1 -: DataW];
        res.leg_invalid = (ram_rdata[LegRamW-1 -: DataW] > DataW'(MaxValidLeg));
        res.position    = ram_rdata[PosW-1:0];
      end
      default: res.kind = KIND_ERROR;
    endcase
    res.last = cmd.last;
  end

  always_comb begin
    st               = '0;
    st.is_cmd        = is_cmd;
    st.pending       = pending;
    st.act_next_none = (act_next == ACT_NONE);
    st.act           = act;
    st.out_free      = !out_valid || out_ready;
    st.leg_last      = ((LegCW'(leg_idx) + LegCW'(1)) == arg_q[LegCW-1:0]);
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken beat");

  a_leg_range: assert property (@(posedge clk) disable iff (rst)
    cmd.leg_read |-> (LegCW'(leg_idx) < arg_q[LegCW-1:0]))
    else $error("leg read past leg count");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= LeftW'(3 * MaxLegs))
    else $error("bytes left out of range");

  a_cmd_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && is_cmd) |=> (bytes_received == '0))
    else $error("command byte did not restart receive count");

endmodule

`default_nettype wire

// ===== rtl/scbp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_ctrl
// Sequencer: accept a byte, report interruption, apply it, emit its results.
// ----------------------------------------------------------------------------
module scbp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scbp_pkg::dp_status_t st,
  output scbp_pkg::dp_cmd_t         cmd
);
  import scbp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_ERR_INT  = 8'b0000_0100,
    S_APPLY    = 8'b0000_1000,
    S_DISPATCH = 8'b0001_0000,
    S_EMIT_ONE = 8'b0010_0000,
    S_LEG_RD   = 8'b0100_0000,
    S_LEG_EMIT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.emit_sel = SEL_ACT;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (st.is_cmd && st.pending) ? S_ERR_INT : S_APPLY;
      end
      S_ERR_INT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_ERR0;
          cmd.last     = st.act_next_none;
          state_next   = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (st.act == ACT_NONE) begin
          state_next = S_IDLE;
        end else if (st.act == ACT_LEGS) begin
          cmd.leg_clear = 1'b1;
          state_next    = S_LEG_RD;
        end else begin
          state_next = S_EMIT_ONE;
        end
      end
      S_EMIT_ONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LEG_RD: begin
        cmd.leg_read = 1'b1;
        state_next   = S_LEG_EMIT;
      end
      S_LEG_EMIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_LEG;
          cmd.last     = st.leg_last;
          cmd.leg_next = 1'b1;
          state_next   = st.leg_last ? S_IDLE : S_LEG_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot({cmd.load_byte, cmd.apply, cmd.emit, cmd.leg_read,
             !(cmd.load_byte || cmd.apply || cmd.emit || cmd.leg_read)}))
    else $error("more than one datapath action in a cycle");

  a_apply_after_check: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> ($past(state) == S_CHECK || $past(state) == S_ERR_INT))
    else $error("byte applied without a check");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.leg_read |=> (state == S_LEG_EMIT))
    else $error("leg read not followed by emit state");

endmodule

`default_nettype wire

// ===== rtl/servo_command_byte_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_byte_parser_top
// Parses a command byte stream and emits one beat per command result.
//
//   channel  dir  handshake               payload
//   s_axis   in   tvalid/tready           tdata: rx_byte
//   m_axis   out  tvalid/tready           tdata/tuser: result, tlast: last
//   cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One byte at a time: a byte is loaded, checked, applied and dispatched. An
// interrupt error is emitted before the apply, any other result after the
// dispatch; a completed move emits each leg: leg store read, then output load.
// The result register frees the input side: a byte is taken while the last
// beat still waits. m_axis stalls hold the sequencer at its next beat.
// Synchronous reset; no clearing pass, the leg store needs none.
// ----------------------------------------------------------------------------
module servo_command_byte_parser_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [6:0] leg, [7] leg_invalid, [21:8] position, [28:22] arg_byte,
  // [30:29] error_code, [31] zero
  output logic [scbp_pkg::OutDataW-1:0]            m_axis_tdata,
  output logic [2:0]                               m_axis_tuser,  // [2:0] kind
  output logic                                     m_axis_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [scbp_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [7:0]                          cfg_data
);
  import scbp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  result_t    res;

  assign cfg_ready = !rst;

  scbp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  scbp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_byte  (s_axis_tdata),
    .cmd      (cmd),
    .st       (st),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (res)
  );

  assign m_axis_tdata = {1'b0, res.error_code, res.arg_byte, res.position,
                         res.leg_invalid, res.leg};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
